// ===== sv/binary_trie_prefix_lookup_defines.svh =====
// Assertion macros for the binary trie prefix lookup block.
// Depends on nothing; the asserting file supplies clk_i and rst_ni.
`ifndef BINARY_TRIE_PREFIX_LOOKUP_DEFINES_SVH
`define BINARY_TRIE_PREFIX_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTPL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/btpl_pkg.sv =====
// Shared types, constants and the record decode function of the trie lookup.
// Depends on nothing; every module of the block imports it.
package btpl_pkg;

  localparam int unsigned RECORD_BITS_W = 6;
  localparam int unsigned NODE_COUNT_W  = 17;
  localparam int unsigned DEPTH_W       = 8;
  localparam int unsigned NODE_IDX_W    = 16;
  localparam int unsigned MEM_DEPTH     = 65536;
  localparam int unsigned PAYLOAD_W     = 128;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = 1;
  localparam int unsigned QCNT_W        = 2;

  localparam logic [RECORD_BITS_W-1:0] WIDTH_24 = 6'd24;
  localparam logic [RECORD_BITS_W-1:0] WIDTH_28 = 6'd28;
  localparam logic [RECORD_BITS_W-1:0] WIDTH_32 = 6'd32;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_LOOKUP,
    KIND_FAIL
  } btpl_kind_e;

  typedef enum logic [1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_CORRUPT = 2'd1,
    STATUS_RANGE   = 2'd2
  } btpl_status_e;

  typedef enum logic [1:0] {
    REG_RECORD_BITS  = 2'd0,
    REG_NODE_COUNT   = 2'd1,
    REG_SEARCH_DEPTH = 2'd2,
    REG_NETMASK_BASE = 2'd3
  } btpl_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } btpl_state_e;

  typedef struct packed {
    logic [RECORD_BITS_W-1:0] record_bits;
    logic [NODE_COUNT_W-1:0]  node_count;
    logic [DEPTH_W-1:0]       search_depth;
    logic [DEPTH_W-1:0]       netmask_base;
  } btpl_cfg_t;

  // A write carries {node_index, node_bytes} in the low 80 bits of the payload,
  // a lookup carries the 128-bit address.
  typedef struct packed {
    btpl_kind_e           kind;
    logic [PAYLOAD_W-1:0] payload;
  } btpl_entry_t;

  function automatic logic [31:0] child_record(input logic [63:0] v,
                                               input logic [RECORD_BITS_W-1:0] width,
                                               input logic right);
    logic [31:0] rec;
    if (width == WIDTH_24) begin
      rec = right ? {8'd0, v[23:0]} : {8'd0, v[47:24]};
    end else if (width == WIDTH_28) begin
      rec = right ? {4'd0, v[27:0]} : {4'd0, v[31:28], v[55:32]};
    end else begin
      rec = right ? v[31:0] : v[63:32];
    end
    return rec;
  endfunction

endpackage

// ===== sv/btpl_front.sv =====
// Front end: classifies accepted items into write, lookup or failing lookup.
// Depends on btpl_pkg.
module btpl_front import btpl_pkg::*; (
  input  btpl_cfg_t             cfg_i,
  input  logic                  opcode_i,
  input  logic [NODE_IDX_W-1:0] node_index_i,
  input  logic [63:0]           node_bytes_i,
  input  logic [63:0]           address_high_i,
  input  logic [63:0]           address_low_i,
  output btpl_entry_t           entry_o
);

  logic width_ok;

  assign width_ok = (cfg_i.record_bits == WIDTH_24) || (cfg_i.record_bits == WIDTH_28) ||
                    (cfg_i.record_bits == WIDTH_32);

  always_comb begin
    if (!opcode_i) begin
      entry_o.kind    = KIND_WRITE;
      entry_o.payload = {48'd0, node_index_i, node_bytes_i};
    end else begin
      // A bad record width or a zero depth fails without touching the tree.
      entry_o.kind    = (width_ok && (cfg_i.search_depth != '0)) ? KIND_LOOKUP : KIND_FAIL;
      entry_o.payload = {address_high_i, address_low_i};
    end
  end

endmodule

// ===== sv/btpl_queue.sv =====
// Two-entry queue that decouples the front end from the tree walker.
// Depends on btpl_pkg.
module btpl_queue import btpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  btpl_entry_t entry_i,
  input  logic        pop_i,
  output btpl_entry_t entry_o,
  output logic        full_o,
  output logic        not_empty_o
);

  btpl_entry_t       slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign entry_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/btpl_back.sv =====
// Back end: owns the node memory, stores written nodes and walks the trie.
// Depends on btpl_pkg.
module btpl_back import btpl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  btpl_cfg_t    cfg_i,
  input  logic         q_valid_i,
  input  btpl_entry_t  entry_i,
  output logic         pop_o,
  output logic         walking_o,
  output logic         result_valid_o,
  output btpl_status_e status_o,
  output logic [7:0]   prefix_length_o,
  output logic [31:0]  data_pointer_o
);

  logic [63:0]           mem_q [MEM_DEPTH];
  logic [63:0]           rdata_q;
  logic [NODE_IDX_W-1:0] rd_addr;

  btpl_state_e           state_q, state_d;
  logic [PAYLOAD_W-1:0]  addr_q, addr_d;
  logic [DEPTH_W-1:0]    bit_q, bit_d;
  logic                  res_valid_q, res_valid_d;
  btpl_status_e          status_q, status_d;
  logic [7:0]            prefix_q, prefix_d;
  logic [31:0]           dptr_q, dptr_d;

  logic                  addr_bit;
  logic [31:0]           rec;
  logic                  is_leaf;
  logic                  mem_we;

  assign pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign walking_o = (state_q == ST_WALK);
  assign mem_we    = pop_o && (entry_i.kind == KIND_WRITE);

  assign addr_bit = bit_q[DEPTH_W-1] ? 1'b0 : addr_q[bit_q[DEPTH_W-2:0]];
  assign rec      = child_record(rdata_q, cfg_i.record_bits, addr_bit);
  assign is_leaf  = (rec >= {15'd0, cfg_i.node_count});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && (entry_i.kind == KIND_LOOKUP)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (is_leaf || (bit_q == '0) || rec[NODE_IDX_W]) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    addr_d      = addr_q;
    bit_d       = bit_q;
    rd_addr     = '0;
    res_valid_d = 1'b0;
    status_d    = STATUS_CORRUPT;
    prefix_d    = '0;
    dptr_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        addr_d = entry_i.payload;
        bit_d  = cfg_i.search_depth - 1'b1;
        if (pop_o && (entry_i.kind == KIND_FAIL)) begin
          res_valid_d = 1'b1;
        end
      end
      ST_WALK: begin
        rd_addr = rec[NODE_IDX_W-1:0];
        bit_d   = bit_q - 1'b1;
        if (is_leaf) begin
          res_valid_d = 1'b1;
          status_d    = STATUS_FOUND;
          prefix_d    = cfg_i.netmask_base - bit_q;
          dptr_d      = rec - {15'd0, cfg_i.node_count};
        end else if (bit_q == '0) begin
          res_valid_d = 1'b1;
        end else if (rec[NODE_IDX_W]) begin
          res_valid_d = 1'b1;
          status_d    = STATUS_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    bit_q    <= bit_d;
    status_q <= status_d;
    prefix_q <= prefix_d;
    dptr_q   <= dptr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[entry_i.payload[64+NODE_IDX_W-1:64]] <= entry_i.payload[63:0];
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = status_q;
  assign prefix_length_o = prefix_q;
  assign data_pointer_o  = dptr_q;

endmodule

// ===== sv/binary_trie_prefix_lookup.sv =====
// Top level of the binary trie prefix lookup: configuration registers and wiring.
// Depends on btpl_pkg, btpl_front, btpl_queue, btpl_back and the defines header.
//
// A write beat stores one 64-bit node and leaves the walker idle. A lookup beat
// reads node 0 through the registered read of the node memory, then walks the
// address bit by bit until it meets a leaf, runs out of search depth or finds a
// node index beyond the memory; the walker takes no new beat while it walks. A
// failing lookup gives its result without a walk. A two-beat queue sits in front
// of the walker, and busy is high only while it is full. Each result is shown for
// one cycle on result_valid_o, in the cycle after the walker finishes with its
// beat, and must be taken then, since the receiver cannot stall. The node memory
// is not cleared at reset, and a lookup must only reach written nodes.
`include "binary_trie_prefix_lookup_defines.svh"

module binary_trie_prefix_lookup import btpl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode_i,
  input  logic [NODE_IDX_W-1:0] node_index_i,
  input  logic [63:0]           node_bytes_i,
  input  logic [63:0]           address_high_i,
  input  logic [63:0]           address_low_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [7:0]            prefix_length_o,
  output logic [31:0]           data_pointer_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  btpl_cfg_t    cfg_q;
  btpl_entry_t  front_entry, queue_entry;
  logic         push;
  logic         pop;
  logic         q_not_empty;
  logic         walking;
  logic         q_full;
  logic         cfg_we;
  btpl_reg_e    reg_sel;
  btpl_status_e status;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = btpl_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_bits  <= WIDTH_24;
      cfg_q.node_count   <= NODE_COUNT_W'(1);
      cfg_q.search_depth <= DEPTH_W'(32);
      cfg_q.netmask_base <= DEPTH_W'(32);
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_RECORD_BITS:  cfg_q.record_bits  <= pwdata[RECORD_BITS_W-1:0];
        REG_NODE_COUNT:   cfg_q.node_count   <= pwdata[NODE_COUNT_W-1:0];
        REG_SEARCH_DEPTH: cfg_q.search_depth <= pwdata[DEPTH_W-1:0];
        REG_NETMASK_BASE: cfg_q.netmask_base <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RECORD_BITS:  prdata = {26'd0, cfg_q.record_bits};
      REG_NODE_COUNT:   prdata = {15'd0, cfg_q.node_count};
      REG_SEARCH_DEPTH: prdata = {24'd0, cfg_q.search_depth};
      REG_NETMASK_BASE: prdata = {24'd0, cfg_q.netmask_base};
      default:          prdata = '0;
    endcase
  end

  assign busy = q_full;
  assign push = start && !busy;

  btpl_front u_front (
    .cfg_i          (cfg_q),
    .opcode_i       (opcode_i),
    .node_index_i   (node_index_i),
    .node_bytes_i   (node_bytes_i),
    .address_high_i (address_high_i),
    .address_low_i  (address_low_i),
    .entry_o        (front_entry)
  );

  btpl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (front_entry),
    .pop_i       (pop),
    .entry_o     (queue_entry),
    .full_o      (q_full),
    .not_empty_o (q_not_empty)
  );

  btpl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_not_empty),
    .entry_i         (queue_entry),
    .pop_o           (pop),
    .walking_o       (walking),
    .result_valid_o  (result_valid_o),
    .status_o        (status),
    .prefix_length_o (prefix_length_o),
    .data_pointer_o  (data_pointer_o)
  );

  assign status_o = status;

  `BTPL_ASSERT_IMPL(a_err_zero, result_valid_o && (status != STATUS_FOUND), (prefix_length_o == '0) && (data_pointer_o == '0), "error result carries nonzero fields")
  `BTPL_ASSERT_NEXT(a_res_source, !pop && !walking, !result_valid_o, "result without a popped beat or a walk step")
  `BTPL_ASSERT_IMPL(a_pop_nonempty, pop, q_not_empty && !walking, "walker popped an empty queue or while walking")

endmodule

// ===== bench/binary_trie_prefix_lookup_tb.sv =====
// Self-checking bench for binary_trie_prefix_lookup: node writes and trie walks are
// sent as command beats under random bursts and gaps, and each result is compared
// with an in-bench walk of a mirrored node memory. Depends on btpl_pkg and the RTL.
module binary_trie_prefix_lookup_tb;
  import btpl_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct {
    btpl_status_e status;
    logic [7:0]   prefix_length;
    logic [31:0]  data_pointer;
  } lookup_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  opcode_i;
  logic [NODE_IDX_W-1:0] node_index_i;
  logic [63:0]           node_bytes_i;
  logic [63:0]           address_high_i;
  logic [63:0]           address_low_i;
  logic                  result_valid_o;
  logic [1:0]            status_o;
  logic [7:0]            prefix_length_o;
  logic [31:0]           data_pointer_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [3:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  logic [63:0]    trie_mem [MEM_DEPTH];
  bit             trie_written [MEM_DEPTH];
  int             trie_nodes[$];
  lookup_result_t expected_lookups[$];

  logic [RECORD_BITS_W-1:0] cfg_width;
  logic [NODE_COUNT_W-1:0]  cfg_count;
  logic [DEPTH_W-1:0]       cfg_depth;
  logic [DEPTH_W-1:0]       cfg_base;

  int fail_count  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  binary_trie_prefix_lookup u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .node_index_i   (node_index_i),
    .node_bytes_i   (node_bytes_i),
    .address_high_i (address_high_i),
    .address_low_i  (address_low_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .prefix_length_o(prefix_length_o),
    .data_pointer_o (data_pointer_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit width_ok();
    return cfg_width == WIDTH_24 || cfg_width == WIDTH_28 || cfg_width == WIDTH_32;
  endfunction

  function automatic logic [31:0] record_mask();
    if (cfg_width == WIDTH_24) return 32'h00FF_FFFF;
    if (cfg_width == WIDTH_28) return 32'h0FFF_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] child_of(logic [63:0] v, bit right);
    if (cfg_width == WIDTH_24)
      return right ? 32'(v & 64'hFF_FFFF) : 32'((v >> 24) & 64'hFF_FFFF);
    if (cfg_width == WIDTH_28)
      return right ? 32'(v & 64'hFFF_FFFF)
                   : 32'(((v >> 32) & 64'hFF_FFFF) | (((v >> 28) & 64'hF) << 24));
    return right ? v[31:0] : v[63:32];
  endfunction

  // Unused high bytes carry random filler, which the block must ignore.
  function automatic logic [63:0] make_node(logic [31:0] left, logic [31:0] right);
    logic [63:0] filler;
    filler = rand64();
    if (cfg_width == WIDTH_24) return {filler[63:48], left[23:0], right[23:0]};
    if (cfg_width == WIDTH_28) return {filler[63:56], left[23:0], left[27:24], right[27:0]};
    return {left, right};
  endfunction

  function automatic logic [31:0] pick_record();
    int r;
    r = $urandom_range(0, 99);
    if (cfg_count > MEM_DEPTH && r < 10) return $urandom_range(MEM_DEPTH, cfg_count - 1);
    if (r < 70 && trie_nodes.size() > 0)
      return trie_nodes[$urandom_range(0, trie_nodes.size() - 1)];
    if (r < 80) return record_mask();
    if (r < 85) return 32'(cfg_count);
    return $urandom_range(cfg_count, record_mask());
  endfunction

  // Returns 0 when the walk would read a node that was never written.
  function automatic bit walk_trie(logic [63:0] hi, logic [63:0] lo,
                                   output lookup_result_t res);
    logic [127:0] addr;
    logic [31:0]  node;
    logic [31:0]  rec;
    logic [7:0]   bitv;
    bit           right;
    res.status        = STATUS_CORRUPT;
    res.prefix_length = 8'd0;
    res.data_pointer  = 32'd0;
    if (!width_ok()) return 1'b1;
    addr = {hi, lo};
    node = 32'd0;
    for (int d = cfg_depth; d > 0; d--) begin
      bitv = 8'(d - 1);
      if (node >= MEM_DEPTH) begin
        res.status = STATUS_RANGE;
        return 1'b1;
      end
      if (!trie_written[node[15:0]]) return 1'b0;
      right = (bitv < 8'd128) ? addr[bitv[6:0]] : 1'b0;
      rec = child_of(trie_mem[node[15:0]], right);
      if (rec >= 32'(cfg_count)) begin
        res.status        = STATUS_FOUND;
        res.prefix_length = cfg_base - bitv;
        res.data_pointer  = rec - 32'(cfg_count);
        return 1'b1;
      end
      node = rec;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(logic op, logic [15:0] idx, logic [63:0] bytes,
                           logic [63:0] hi, logic [63:0] lo);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    start          <= 1'b1;
    opcode_i       <= op;
    node_index_i   <= idx;
    node_bytes_i   <= bytes;
    address_high_i <= hi;
    address_low_i  <= lo;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic store_node(logic [15:0] idx, logic [63:0] bytes);
    send_beat(OP_WRITE, idx, bytes, rand64(), rand64());
    trie_mem[idx]     = bytes;
    trie_written[idx] = 1'b1;
  endtask

  task automatic look_up(logic [63:0] hi, logic [63:0] lo);
    lookup_result_t res;
    if (walk_trie(hi, lo, res)) begin
      send_beat(OP_LOOKUP, 16'($urandom), rand64(), hi, lo);
      expected_lookups.push_back(res);
    end
  endtask

  // Write beats give no result, so the task idles on after the last expected result to let queued writes retire.
  task automatic drain_block();
    start <= 1'b0;
    burst_left = 0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(btpl_reg_e r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (r)
      REG_RECORD_BITS:  cfg_width = value[RECORD_BITS_W-1:0];
      REG_NODE_COUNT:   cfg_count = value[NODE_COUNT_W-1:0];
      REG_SEARCH_DEPTH: cfg_depth = value[DEPTH_W-1:0];
      REG_NETMASK_BASE: cfg_base  = value[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [5:0] w, logic [16:0] n, logic [7:0] d, logic [7:0] b);
    drain_block();
    write_register(REG_RECORD_BITS, 32'(w));
    write_register(REG_NODE_COUNT, 32'(n));
    write_register(REG_SEARCH_DEPTH, 32'(d));
    write_register(REG_NETMASK_BASE, 32'(b));
  endtask

  task automatic build_trie();
    int n;
    int limit;
    trie_nodes.delete();
    if (cfg_count <= 64) begin
      for (int i = 0; i < ((cfg_count == 0) ? 1 : int'(cfg_count)); i++)
        trie_nodes.push_back(i);
    end else begin
      limit = (cfg_count > MEM_DEPTH) ? MEM_DEPTH : int'(cfg_count);
      n = $urandom_range(2, 24);
      trie_nodes.push_back(0);
      repeat (n - 1) trie_nodes.push_back($urandom_range(1, limit - 1));
    end
    foreach (trie_nodes[i])
      store_node(16'(trie_nodes[i]), make_node(pick_record(), pick_record()));
  endtask

  task automatic run_random_phase(int items);
    int r;
    if (width_ok()) build_trie();
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        look_up(rand64(), rand64());
      else if (r < 76)
        look_up({64{r[0]}}, {64{r[0]}});
      else if (r < 92 && width_ok() && trie_nodes.size() > 0)
        store_node(16'(trie_nodes[$urandom_range(0, trie_nodes.size() - 1)]),
                   make_node(pick_record(), pick_record()));
      else
        store_node(16'($urandom), rand64());
    end
  endtask

  task automatic test_reset_config();
    store_node(16'd0, {16'hBEEF, 24'h00_0000, 24'h00_0005});
    look_up(64'd0, 64'h8000_0000);
    look_up(rand64(), 64'd1);
    look_up(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
  endtask

  task automatic test_record_widths();
    logic [5:0]  w;
    logic [31:0] top;
    for (int i = 0; i < 3; i++) begin
      w = (i == 0) ? WIDTH_24 : (i == 1) ? WIDTH_28 : WIDTH_32;
      set_config(w, 17'd2, 8'd32, 8'd32);
      top = record_mask();
      store_node(16'd0, make_node(32'd1, top));
      store_node(16'd1, make_node(top ^ 32'd5, 32'd0));
      look_up(rand64(), 64'd0);
      look_up(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    end
    set_config(6'd0, 17'd2, 8'd32, 8'd32);
    look_up(rand64(), rand64());
    set_config(6'd63, 17'd2, 8'd32, 8'd32);
    look_up(rand64(), rand64());
  endtask

  task automatic test_depth_and_prefix();
    set_config(WIDTH_32, 17'd2, 8'd0, 8'd32);
    look_up(rand64(), rand64());
    set_config(WIDTH_32, 17'd2, 8'd255, 8'd0);
    look_up(rand64(), rand64());
    set_config(WIDTH_32, 17'd2, 8'd128, 8'd128);
    look_up({1'b1, 63'(rand64())}, rand64());
  endtask

  task automatic test_node_range();
    set_config(WIDTH_24, 17'h1FFFF, 8'd2, 8'd32);
    store_node(16'd0, make_node(32'd70000, 32'h00FF_FFFF));
    look_up(64'd0, 64'd0);
    set_config(WIDTH_24, 17'h1FFFF, 8'd1, 8'd32);
    look_up(64'd0, 64'd0);
  endtask

  task automatic test_random_traffic();
    logic [5:0]  w;
    logic [16:0] n;
    set_config(WIDTH_24, 17'd1, 8'd128, 8'd128);
    run_random_phase(90);
    set_config(WIDTH_32, 17'h10000, 8'd1, 8'd1);
    run_random_phase(90);
    set_config(WIDTH_28, 17'd20, 8'd40, 8'd255);
    run_random_phase(90);
    set_config(WIDTH_32, 17'h1FFFF, 8'd20, 8'd64);
    run_random_phase(90);
    do w = 6'($urandom); while (w == WIDTH_24 || w == WIDTH_28 || w == WIDTH_32);
    set_config(w, 17'($urandom), 8'($urandom), 8'($urandom));
    run_random_phase(40);
    repeat (5) begin
      case ($urandom_range(0, 2))
        0:       w = WIDTH_24;
        1:       w = WIDTH_28;
        default: w = WIDTH_32;
      endcase
      case ($urandom_range(0, 3))
        0:       n = 17'($urandom_range(0, 64));
        1:       n = 17'h10000;
        2:       n = 17'($urandom_range(65, 17'h1FFFF));
        default: n = 17'($urandom_range(2, 16));
      endcase
      set_config(w, n,
                 ($urandom_range(0, 4) == 0) ? 8'($urandom_range(100, 255))
                                             : 8'($urandom_range(0, 48)),
                 8'($urandom));
      run_random_phase(90);
    end
  endtask

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_lookups.size() == 0) begin
        $error("result beat with no lookup pending: status %0d", status_o);
        fail_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (prefix_length_o !== want.prefix_length) begin
          $error("prefix_length: expected %0d, got %0d", want.prefix_length, prefix_length_o);
          fail_count++;
        end
        if (data_pointer_o !== want.data_pointer) begin
          $error("data_pointer: expected %0h, got %0h", want.data_pointer, data_pointer_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[binary_trie_prefix_lookup] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    opcode_i       = OP_WRITE;
    node_index_i   = '0;
    node_bytes_i   = '0;
    address_high_i = '0;
    address_low_i  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_width      = WIDTH_24;
    cfg_count      = 17'd1;
    cfg_depth      = 8'd32;
    cfg_base       = 8'd32;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_record_widths();
    test_depth_and_prefix();
    test_node_range();
    test_random_traffic();
    drain_block();
    if (fail_count == 0) begin
      $display("[binary_trie_prefix_lookup] OK");
    end else begin
      $display("[binary_trie_prefix_lookup] ERROR");
    end
    $finish;
  end

endmodule
